FILE: rtl/bqps_pkg.sv
// ----------------------------------------------------------------------------
// bqps_pkg: shared types and constants of the biquadratic patch sampler
// Fixed field widths, operation and status codes, the sequencer state type
// and the schedule table that drives the shared multiply-accumulate lanes.
// ----------------------------------------------------------------------------
package bqps_pkg;

   localparam int NUM_COMP  = 5;      // x, y, z, s, t
   localparam int COMP_W    = 32;     // signed Q16.16 component
   localparam int PARAM_W   = 17;     // unsigned Q1.16 parameter, up to 1.0
   localparam int WEIGHT_W  = 33;     // Bernstein weight in Q1.32, up to 1.0
   localparam int PROD_W    = WEIGHT_W + 1 + COMP_W;
   localparam int ACC_W     = PROD_W;
   localparam int CNT_W     = 4;

   localparam logic [PARAM_W-1:0]  PARAM_ONE  = 17'h1_0000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 33'h1_0000_0000;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 66'sh0_8000_0000;

   localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOB = 1'b1;

   localparam logic PHASE_U = 1'b0;
   localparam logic PHASE_V = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // One step of the evaluation schedule as it travels down the lanes.
   typedef struct packed {
      logic       valid;
      logic       phase;   // u curve over window rows, or final v curve
      logic [1:0] row;     // window row (u phase)
      logic [1:0] col;     // Bernstein term index
   } tag_type;

   // Steps 0..8 read the nine window points row by row; steps 11..13 run
   // the v curve once the last row result has been stored.
   function automatic tag_type sched_tag(input logic [CNT_W-1:0] step);
      tag_type t;
      t = '0;
      case (step)
         4'd0:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd0, col: 2'd0};
         4'd1:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd0, col: 2'd1};
         4'd2:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd0, col: 2'd2};
         4'd3:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd1, col: 2'd0};
         4'd4:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd1, col: 2'd1};
         4'd5:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd1, col: 2'd2};
         4'd6:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd2, col: 2'd0};
         4'd7:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd2, col: 2'd1};
         4'd8:  t = '{valid: 1'b1, phase: PHASE_U, row: 2'd2, col: 2'd2};
         4'd11: t = '{valid: 1'b1, phase: PHASE_V, row: 2'd0, col: 2'd0};
         4'd12: t = '{valid: 1'b1, phase: PHASE_V, row: 2'd0, col: 2'd1};
         4'd13: t = '{valid: 1'b1, phase: PHASE_V, row: 2'd0, col: 2'd2};
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/bqps_ram.sv
// ----------------------------------------------------------------------------
// bqps_ram: generic single write port RAM with registered read
// One write and one read address per cycle; read data is registered and appears in the cycle after its address.
// ----------------------------------------------------------------------------
module bqps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/biquadratic_patch_sampler.sv
// ----------------------------------------------------------------------------
// biquadratic_patch_sampler: quadratic Bezier patch evaluation over a mesh
// Stores a MESH_SIZE x MESH_SIZE grid of five-component control points and
// samples a 3x3 window at (u, v) with five shared multiply-accumulate lanes.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  -------------------------------
//  request   req_* (op, col, row, comp,      taken when start && !busy
//            value, u_param, v_param)
//  response  rsp_status, rsp_out_*           one cycle, marked by rsp_valid
//
// A write transaction stores one component in the cycle it is taken and
// gives no response. An out-of-bounds sample answers in the next cycle.
// A valid sample keeps the block busy through the step schedule: nine
// window points stream out of the single memory read port one per cycle,
// two idle steps let the last row curve land, three v curve steps run
// through the same lanes, and the multiply, accumulate and round stages
// drain the last step. busy drops and the response strobe rises at the
// same edge. Reset clears the sequencer and the strobe, not the point
// memory. rsp_valid cannot be held off, so nothing inside ever waits
// on the receiver.
//
module biquadratic_patch_sampler
   import bqps_pkg::*;
#(
   parameter int MESH_SIZE = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic [3:0]                 req_col,
   input  logic [3:0]                 req_row,
   input  logic [2:0]                 req_component,
   input  logic signed [COMP_W-1:0]   req_value,
   input  logic [PARAM_W-1:0]         req_u_param,
   input  logic [PARAM_W-1:0]         req_v_param,
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic signed [COMP_W-1:0]   rsp_out_x,
   output logic signed [COMP_W-1:0]   rsp_out_y,
   output logic signed [COMP_W-1:0]   rsp_out_z,
   output logic signed [COMP_W-1:0]   rsp_out_s,
   output logic signed [COMP_W-1:0]   rsp_out_t
);

   localparam int DEPTH = MESH_SIZE * MESH_SIZE;
   localparam int AW    = $clog2(DEPTH);

   // Round half up already folded in by the accumulator bias; take the
   // integer part and clamp to the 32-bit range.
   function automatic logic signed [COMP_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-33:0] r;
      r = a[ACC_W-1:32];
      if (r > $signed({2'b00, 32'h7FFF_FFFF})) begin
         return 32'sh7FFF_FFFF;
      end else if (r < $signed({2'b11, 32'h8000_0000})) begin
         return 32'sh8000_0000;
      end else begin
         return r[COMP_W-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   logic accept;
   logic is_write;
   logic is_sample;
   logic oob;
   logic wr_ok;

   assign accept    = start && !busy;
   assign is_write  = (req_operation == OP_WRITE);
   assign is_sample = (req_operation == OP_SAMPLE);
   assign oob       = (32'(req_col) > MESH_SIZE - 3) || (32'(req_row) > MESH_SIZE - 3);
   assign wr_ok     = (32'(req_col) < MESH_SIZE) && (32'(req_row) < MESH_SIZE) &&
                      (32'(req_component) < NUM_COMP);

   // Bernstein weights: w0 = q^2, w2 = p^2, w1 = 1 - w0 - w2 (they sum to 1.0)
   logic [PARAM_W-1:0]  pu, qu, pv, qv;
   logic [WEIGHT_W-1:0] wu_in [3];
   logic [WEIGHT_W-1:0] wv_in [3];

   always_comb begin
      pu = (req_u_param > PARAM_ONE) ? PARAM_ONE : req_u_param;
      pv = (req_v_param > PARAM_ONE) ? PARAM_ONE : req_v_param;
      qu = PARAM_ONE - pu;
      qv = PARAM_ONE - pv;
      wu_in[0] = WEIGHT_W'(qu) * WEIGHT_W'(qu);
      wu_in[2] = WEIGHT_W'(pu) * WEIGHT_W'(pu);
      wu_in[1] = WEIGHT_ONE - wu_in[0] - wu_in[2];
      wv_in[0] = WEIGHT_W'(qv) * WEIGHT_W'(qv);
      wv_in[2] = WEIGHT_W'(pv) * WEIGHT_W'(pv);
      wv_in[1] = WEIGHT_ONE - wv_in[0] - wv_in[2];
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run;
   logic             finish;
   tag_type          s0_tag;
   tag_type          s1_ff, s2_ff, s3_ff;

   assign finish = s3_ff.valid && (s3_ff.phase == PHASE_V) && (s3_ff.col == 2'd2);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_sample && !oob) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy = 1'b0;
      run  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            run  = 1'b0;
         end
         ST_RUN: begin
            busy = 1'b1;
            run  = 1'b1;
         end
         default: begin
            busy = 1'b0;
            run  = 1'b0;
         end
      endcase
   end

   // Step counter: restart on any accepted request, hold at the top once past the
   // schedule so no step issues twice.
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (run && (cnt_ff != CNT_MAX)) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      s0_tag = sched_tag(cnt_ff);
      s0_tag.valid = s0_tag.valid && run;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         s3_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         s1_ff    <= s0_tag;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Point memory: one RAM per component, all read at the same address,
   // so one whole point arrives per cycle.
   // ------------------------------------------------------------------
   logic [3:0]        col_ff, col_in;
   logic [3:0]        row_ff, row_in;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_col, rd_row, rd_addr;
   logic [COMP_W-1:0] ram_q [NUM_COMP];

   assign wr_addr = AW'(AW'(req_col) * AW'(MESH_SIZE)) + AW'(req_row);
   assign rd_col  = AW'(col_ff) + AW'(s0_tag.col);
   assign rd_row  = AW'(row_ff) + AW'(s0_tag.row);
   assign rd_addr = AW'(rd_col * AW'(MESH_SIZE)) + rd_row;

   for (genvar l = 0; l < NUM_COMP; l++) begin : g_ram
      bqps_ram #(
         .WIDTH (COMP_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (accept && is_write && wr_ok && (32'(req_component) == l)),
         .wr_addr (wr_addr),
         .wr_data (req_value),
         .rd_addr (rd_addr),
         .rd_data (ram_q[l])
      );
   end

   // ------------------------------------------------------------------
   // Multiply-accumulate lanes, one per component
   // ------------------------------------------------------------------
   logic [WEIGHT_W-1:0]        wu_ff [3];
   logic [WEIGHT_W-1:0]        wv_ff [3];
   logic [WEIGHT_W-1:0]        wu_hold [3];
   logic [WEIGHT_W-1:0]        wv_hold [3];
   logic signed [WEIGHT_W:0]   w_sel;
   logic signed [COMP_W-1:0]   d_sel  [NUM_COMP];
   logic signed [PROD_W-1:0]   prod_ff [NUM_COMP];
   logic signed [PROD_W-1:0]   prod_in [NUM_COMP];
   logic signed [ACC_W-1:0]    acc_ff  [NUM_COMP];
   logic signed [ACC_W-1:0]    acc_in  [NUM_COMP];
   logic signed [COMP_W-1:0]   line_ff [3][NUM_COMP];
   logic signed [COMP_W-1:0]   line_in [3][NUM_COMP];

   // Capture the sample request on acceptance; hold otherwise.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      for (int k = 0; k < 3; k++) begin
         wu_hold[k] = wu_ff[k];
         wv_hold[k] = wv_ff[k];
      end
      if (accept && is_sample) begin
         col_in = req_col;
         row_in = req_row;
         for (int k = 0; k < 3; k++) begin
            wu_hold[k] = wu_in[k];
            wv_hold[k] = wv_in[k];
         end
      end
   end

   // Multiply stage: weight by term index, operand from memory or from the
   // stored row results.
   always_comb begin
      w_sel = (s1_ff.phase == PHASE_V) ? $signed({1'b0, wv_ff[s1_ff.col]})
                                       : $signed({1'b0, wu_ff[s1_ff.col]});
      for (int l = 0; l < NUM_COMP; l++) begin
         d_sel[l]   = (s1_ff.phase == PHASE_V) ? line_ff[s1_ff.col][l]
                                               : $signed(ram_q[l]);
         prod_in[l] = s1_ff.valid ? (w_sel * d_sel[l]) : prod_ff[l];
      end
   end

   // Accumulate stage: the first term starts from the rounding bias.
   always_comb begin
      for (int l = 0; l < NUM_COMP; l++) begin
         acc_in[l] = acc_ff[l];
         if (s2_ff.valid) begin
            acc_in[l] = ((s2_ff.col == 2'd0) ? ROUND_BIAS : acc_ff[l]) + prod_ff[l];
         end
      end
   end

   // Round stage: store a finished row curve for the v pass.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int l = 0; l < NUM_COMP; l++) begin
            line_in[r][l] = line_ff[r][l];
            if (s3_ff.valid && (s3_ff.phase == PHASE_U) && (s3_ff.col == 2'd2) &&
                (32'(s3_ff.row) == r)) begin
               line_in[r][l] = sat32(acc_ff[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      for (int k = 0; k < 3; k++) begin
         wu_ff[k] <= wu_hold[k];
         wv_ff[k] <= wv_hold[k];
      end
      for (int l = 0; l < NUM_COMP; l++) begin
         prod_ff[l] <= prod_in[l];
         acc_ff[l]  <= acc_in[l];
      end
      for (int r = 0; r < 3; r++) begin
         for (int l = 0; l < NUM_COMP; l++) begin
            line_ff[r][l] <= line_in[r][l];
         end
      end
   end

   // ------------------------------------------------------------------
   // Response register: loaded by the final v step or by an out-of-bounds
   // sample, shown for exactly one cycle.
   // ------------------------------------------------------------------
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic signed [COMP_W-1:0] rsp_comp_ff [NUM_COMP];
   logic signed [COMP_W-1:0] rsp_comp_in [NUM_COMP];

   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      for (int l = 0; l < NUM_COMP; l++) begin
         rsp_comp_in[l] = rsp_comp_ff[l];
      end
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         for (int l = 0; l < NUM_COMP; l++) begin
            rsp_comp_in[l] = sat32(acc_ff[l]);
         end
      end else if (accept && is_sample && oob) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OOB;
         for (int l = 0; l < NUM_COMP; l++) begin
            rsp_comp_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      for (int l = 0; l < NUM_COMP; l++) begin
         rsp_comp_ff[l] <= rsp_comp_in[l];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_x  = rsp_comp_ff[0];
   assign rsp_out_y  = rsp_comp_ff[1];
   assign rsp_out_z  = rsp_comp_ff[2];
   assign rsp_out_s  = rsp_comp_ff[3];
   assign rsp_out_t  = rsp_comp_ff[4];

endmodule

FILE: sim/patch_sample_checker.sv
// ----------------------------------------------------------------------------
// patch_sample_checker: response predictor and comparator for the sampler
// Mirrors the control point mesh from observed write transactions, predicts
// every sample transaction and compares each response field by field.
// ----------------------------------------------------------------------------
module patch_sample_checker
   import bqps_pkg::*;
#(
   parameter int MESH_SIZE = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_operation,
   input  logic [3:0]                 req_col,
   input  logic [3:0]                 req_row,
   input  logic [2:0]                 req_component,
   input  logic signed [COMP_W-1:0]   req_value,
   input  logic [PARAM_W-1:0]         req_u_param,
   input  logic [PARAM_W-1:0]         req_v_param,
   input  logic                       rsp_valid,
   input  logic                       rsp_status,
   input  logic signed [COMP_W-1:0]   rsp_out_x,
   input  logic signed [COMP_W-1:0]   rsp_out_y,
   input  logic signed [COMP_W-1:0]   rsp_out_z,
   input  logic signed [COMP_W-1:0]   rsp_out_s,
   input  logic signed [COMP_W-1:0]   rsp_out_t,
   output int                         mismatches,
   output int                         outstanding
);

   typedef struct packed {
      logic                             status;
      logic [NUM_COMP-1:0][COMP_W-1:0]  comps;   // index 0 is x
   } patch_sample_type;

   localparam logic signed [67:0] HALF_LSB = 68'sh8000_0000;
   localparam logic signed [67:0] SAT_HI   = 68'sh7FFF_FFFF;
   localparam logic signed [67:0] SAT_LO   = -68'sh8000_0000;

   logic [COMP_W-1:0] point_mem [MESH_SIZE][MESH_SIZE][NUM_COMP];
   patch_sample_type  expected_samples [$];
   int                error_count = 0;
   int                pending     = 0;
   string             comp_name [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_s", "out_t"};

   assign mismatches  = error_count;
   assign outstanding = pending;

   initial begin
      foreach (point_mem[i, j, k]) point_mem[i][j][k] = '0;
   end

   // Quadratic Bernstein blend in Q1.32 weights, round half up, saturate.
   function automatic logic signed [COMP_W-1:0] bezier_eval(
      input logic signed [COMP_W-1:0] a,
      input logic signed [COMP_W-1:0] b,
      input logic signed [COMP_W-1:0] c,
      input logic [PARAM_W-1:0]       p
   );
      logic signed [67:0] pw, qw, sa, sb, sc, acc;
      pw  = 68'(p);
      qw  = 68'sd65536 - pw;
      sa  = a;
      sb  = b;
      sc  = c;
      acc = qw * qw * sa + 68'sd2 * pw * qw * sb + pw * pw * sc;
      acc = (acc + HALF_LSB) >>> 32;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      return acc[COMP_W-1:0];
   endfunction

   function automatic patch_sample_type predict_sample(
      input logic [3:0]         col,
      input logic [3:0]         row,
      input logic [PARAM_W-1:0] u,
      input logic [PARAM_W-1:0] v
   );
      patch_sample_type          res;
      logic signed [COMP_W-1:0]  line [3];
      logic [PARAM_W-1:0]        uc, vc;
      int                        ci, ri;
      res = '0;
      ci  = col;
      ri  = row;
      if (ci > MESH_SIZE - 3 || ri > MESH_SIZE - 3) begin
         res.status = STATUS_OOB;
         return res;
      end
      uc = (u > PARAM_ONE) ? PARAM_ONE : u;
      vc = (v > PARAM_ONE) ? PARAM_ONE : v;
      res.status = STATUS_OK;
      for (int k = 0; k < NUM_COMP; k++) begin
         for (int i = 0; i < 3; i++) begin
            line[i] = bezier_eval(point_mem[ci][ri+i][k], point_mem[ci+1][ri+i][k],
                                  point_mem[ci+2][ri+i][k], uc);
         end
         res.comps[k] = bezier_eval(line[0], line[1], line[2], vc);
      end
      return res;
   endfunction

   task automatic note_error(input string what, input logic [COMP_W-1:0] want,
                             input logic [COMP_W-1:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t ERROR %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      patch_sample_type want, got;
      if (!reset) begin
         // Compare first: a response never belongs to a transaction taken at the same edge.
         if (rsp_valid) begin
            got.status = rsp_status;
            got.comps  = {rsp_out_t, rsp_out_s, rsp_out_z, rsp_out_y, rsp_out_x};
            if (expected_samples.size() == 0) begin
               note_error("response with no sample pending, status", '0, 32'(got.status));
            end else begin
               want = expected_samples.pop_front();
               if (got.status !== want.status) begin
                  note_error("rsp_status", 32'(want.status), 32'(got.status));
               end
               for (int k = 0; k < NUM_COMP; k++) begin
                  if (got.comps[k] !== want.comps[k]) begin
                     note_error(comp_name[k], want.comps[k], got.comps[k]);
                  end
               end
            end
         end
         if (start && !busy) begin
            if (req_operation == OP_SAMPLE) begin
               expected_samples.push_back(
                  predict_sample(req_col, req_row, req_u_param, req_v_param));
            end else if (req_component < NUM_COMP && req_col < MESH_SIZE
                         && req_row < MESH_SIZE) begin
               point_mem[req_col][req_row][req_component] = req_value;
            end
         end
         pending = expected_samples.size();
      end
   end

endmodule

FILE: sim/biquadratic_patch_sampler_tb.sv
// ----------------------------------------------------------------------------
// biquadratic_patch_sampler_tb: stimulus and verdict for the patch sampler
// Loads control point windows, samples them with edge and random parameters,
// mixes in out-of-bounds and ignored transactions under varying sender idling,
// and reports the outcome of the side-by-side checker.
// ----------------------------------------------------------------------------
module biquadratic_patch_sampler_tb;
   import bqps_pkg::*;

   localparam int MESH        = 16;
   localparam int ITEMS       = 1600;
   localparam int SETTLE      = 40;     // longer than a sample takes to answer
   localparam int DRAIN_LIMIT = 1000;

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      start         = 1'b0;
   logic                      busy;
   logic                      req_operation = OP_WRITE;
   logic [3:0]                req_col       = '0;
   logic [3:0]                req_row       = '0;
   logic [2:0]                req_component = '0;
   logic signed [COMP_W-1:0]  req_value     = '0;
   logic [PARAM_W-1:0]        req_u_param   = '0;
   logic [PARAM_W-1:0]        req_v_param   = '0;
   logic                      rsp_valid;
   logic                      rsp_status;
   logic signed [COMP_W-1:0]  rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_s, rsp_out_t;
   int                        mismatches;
   int                        outstanding;

   // Which point components hold a written value; the mesh powers up undefined,
   // so a window is sampled only once all 45 of its components are set.
   bit loaded [MESH][MESH][NUM_COMP];
   int idle_pct       = 0;
   int accepted_items = 0;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   biquadratic_patch_sampler #(
      .MESH_SIZE (MESH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_component (req_component),
      .req_value     (req_value),
      .req_u_param   (req_u_param),
      .req_v_param   (req_v_param),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_s     (rsp_out_s),
      .rsp_out_t     (rsp_out_t)
   );

   patch_sample_checker #(
      .MESH_SIZE (MESH)
   ) sample_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_component (req_component),
      .req_value     (req_value),
      .req_u_param   (req_u_param),
      .req_v_param   (req_v_param),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_s     (rsp_out_s),
      .rsp_out_t     (rsp_out_t),
      .mismatches    (mismatches),
      .outstanding   (outstanding)
   );

   // Hard stop far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [COMP_W-1:0] rand_value();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'($urandom_range(32'h3_FFFF)) - 32'h2_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [PARAM_W-1:0] rand_param();
      case ($urandom_range(7))
         0:       return '0;
         1:       return PARAM_ONE;
         2:       return PARAM_W'(32'h1_0001 + $urandom_range(65534));   // clamped to one
         default: return PARAM_W'($urandom_range(65536));
      endcase
   endfunction

   // Offer one transaction and hold it until the block takes it. Random idle
   // cycles go in front, so start rises at any point of the block's work.
   task automatic send_item(input logic op, input logic [3:0] col, input logic [3:0] row,
                            input logic [2:0] comp, input logic [COMP_W-1:0] value,
                            input logic [PARAM_W-1:0] u, input logic [PARAM_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_col       <= col;
      req_row       <= row;
      req_component <= comp;
      req_value     <= value;
      req_u_param   <= u;
      req_v_param   <= v;
      // busy only moves at rising edges, so the falling edge shows what the
      // next rising edge will see.
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (!(op == OP_WRITE && comp >= NUM_COMP)) accepted_items++;
   endtask

   // Write one component; ignored codes leave the loaded map alone.
   task automatic put_comp(input int col, input int row, input int comp,
                           input logic [COMP_W-1:0] value);
      send_item(OP_WRITE, 4'(col), 4'(row), 3'(comp), value,
                PARAM_W'($urandom), PARAM_W'($urandom));
      if (comp < NUM_COMP) loaded[col][row][comp] = 1'b1;
   endtask

   task automatic take_sample(input int col, input int row,
                              input logic [PARAM_W-1:0] u, input logic [PARAM_W-1:0] v);
      send_item(OP_SAMPLE, 4'(col), 4'(row), 3'($urandom), $urandom, u, v);
   endtask

   // Fill every still-unwritten component of the 3x3 window at (col, row).
   task automatic load_window(input int col, input int row);
      for (int dc = 0; dc < 3; dc++) begin
         for (int dr = 0; dr < 3; dr++) begin
            for (int k = 0; k < NUM_COMP; k++) begin
               if (!loaded[col+dc][row+dr][k]) put_comp(col + dc, row + dr, k, rand_value());
            end
         end
      end
   endtask

   // Hold start low until every expected response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // One stretch of random traffic at a given sender idle rate.
   task automatic run_phase(input int pct, input int quota);
      int target, c, r, pick;
      idle_pct = pct;
      target   = accepted_items + quota;
      while (accepted_items < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            // well-formed: load the window, touch it up, sample it
            c = $urandom_range(MESH - 3);
            r = $urandom_range(MESH - 3);
            load_window(c, r);
            repeat ($urandom_range(2)) begin
               put_comp(c + $urandom_range(2), r + $urandom_range(2),
                        $urandom_range(NUM_COMP - 1), rand_value());
            end
            repeat (1 + $urandom_range(1)) take_sample(c, r, rand_param(), rand_param());
         end else if (pick < 80) begin
            c = $urandom_range(MESH - 1, MESH - 2);
            r = $urandom_range(MESH - 1);
            if ($urandom_range(1)) take_sample(c, r, rand_param(), rand_param());
            else take_sample(r, c, rand_param(), rand_param());
         end else if (pick < 90) begin
            put_comp($urandom_range(MESH - 1), $urandom_range(MESH - 1),
                     $urandom_range(NUM_COMP - 1), rand_value());
         end else begin
            // bad component code: the block must drop it
            put_comp($urandom_range(MESH - 1), $urandom_range(MESH - 1),
                     $urandom_range(7, NUM_COMP), rand_value());
         end
      end
      drain_responses();
   endtask

   initial begin
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: load the far corner window, then sample it at the parameter
      // extremes, including values above one.
      idle_pct = 6;
      load_window(MESH - 3, MESH - 3);
      take_sample(MESH - 3, MESH - 3, '0, '0);
      take_sample(MESH - 3, MESH - 3, PARAM_ONE, PARAM_ONE);
      take_sample(MESH - 3, MESH - 3, '0, PARAM_ONE);
      take_sample(MESH - 3, MESH - 3, PARAM_ONE, '0);
      take_sample(MESH - 3, MESH - 3, 17'h0_8000, 17'h0_8000);
      take_sample(MESH - 3, MESH - 3, 17'h0_0001, 17'h0_FFFF);
      take_sample(MESH - 3, MESH - 3, 17'h1_FFFF, 17'h1_0001);

      // Out-of-bounds window offsets along each axis and both.
      take_sample(MESH - 2, 0, PARAM_ONE, '0);
      take_sample(0, MESH - 2, 17'h1_FFFF, 17'h1_FFFF);
      take_sample(MESH - 1, MESH - 1, '0, '0);
      take_sample(MESH - 2, MESH - 3, 17'h0_4000, 17'h0_C000);
      take_sample(MESH - 3, MESH - 1, 17'h0_4000, 17'h0_C000);

      // Bad component codes must leave the window unchanged.
      put_comp(MESH - 3, MESH - 3, NUM_COMP, 32'h7FFF_FFFF);
      put_comp(MESH - 2, MESH - 2, 7, 32'h8000_0000);
      take_sample(MESH - 3, MESH - 3, 17'h0_8000, 17'h0_8000);

      // Value extremes on the corner point, read back at u = v = 1.
      put_comp(MESH - 1, MESH - 1, 0, 32'h7FFF_FFFF);
      put_comp(MESH - 1, MESH - 1, 1, 32'h8000_0000);
      take_sample(MESH - 3, MESH - 3, PARAM_ONE, PARAM_ONE);
      drain_responses();

      // Random traffic: light sender idling, heavy idling, then none.
      run_phase(6, ITEMS / 3);
      run_phase(66, ITEMS / 3);
      run_phase(0, ITEMS - 2 * (ITEMS / 3));

      start  <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
